// ===== src/amoc_pkg.sv =====
// Shared types and constants for the audio mix to output converter.
// No dependencies; every other file refers to it by scoped names.
package amoc_pkg;

  localparam int GAIN_SHIFT_DEF = 8;
  localparam int PAN_W          = 10;
  localparam int MIX_W          = 32;
  localparam int SAMPLE_W       = 16;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic REG_PAN = 1'b0;
  localparam logic REG_FMT = 1'b1;

  localparam logic [1:0] WORDS_MONO   = 2'd1;
  localparam logic [1:0] WORDS_STEREO = 2'd2;

  localparam logic [7:0] BYTE_SIGN = 8'h80;

  typedef enum logic [1:0] {
    FMT_MONO8    = 2'd0,
    FMT_STEREO8  = 2'd1,
    FMT_MONO16   = 2'd2,
    FMT_STEREO16 = 2'd3
  } fmt_e;

  typedef struct packed {
    logic signed [PAN_W-1:0] pan;
    fmt_e                    fmt;
  } cfg_t;

endpackage

// ===== src/amoc_regs.sv =====
// Configuration register file behind the APB-style port: pan and format.
// Depends on amoc_pkg.
module amoc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [amoc_pkg::ADDR_W-1:0] paddr,
  input  logic [amoc_pkg::DATA_W-1:0] pwdata,
  output logic [amoc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output amoc_pkg::cfg_t              cfg_o
);

  logic signed [amoc_pkg::PAN_W-1:0] pan_q;
  amoc_pkg::fmt_e                    fmt_q;
  logic                              wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q <= '0;
      fmt_q <= amoc_pkg::FMT_STEREO16;
    end else if (wr_en) begin
      unique case (paddr[2])
        amoc_pkg::REG_PAN: pan_q <= pwdata[amoc_pkg::PAN_W-1:0];
        amoc_pkg::REG_FMT: fmt_q <= amoc_pkg::fmt_e'(pwdata[1:0]);
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      amoc_pkg::REG_PAN: prdata = {{(amoc_pkg::DATA_W-amoc_pkg::PAN_W){1'b0}}, pan_q};
      amoc_pkg::REG_FMT: prdata = {{(amoc_pkg::DATA_W-2){1'b0}}, fmt_q};
    endcase
  end

  assign cfg_o.pan = pan_q;
  assign cfg_o.fmt = fmt_q;

endmodule

// ===== src/amoc_gain.sv =====
// Pan law: turns the signed pan setting into left and right channel gains.
// Depends on amoc_pkg.
module amoc_gain #(
  parameter int GAIN_SHIFT = amoc_pkg::GAIN_SHIFT_DEF
) (
  input  logic signed [amoc_pkg::PAN_W-1:0] pan_i,
  output logic        [GAIN_SHIFT:0]        gain_left_o,
  output logic        [GAIN_SHIFT:0]        gain_right_o
);

  localparam int GW = GAIN_SHIFT + 1;
  localparam int MW = (GW > amoc_pkg::PAN_W) ? GW : amoc_pkg::PAN_W;
  localparam logic [MW-1:0] UNITY = MW'(2 ** GAIN_SHIFT);

  logic [amoc_pkg::PAN_W-1:0] pan_abs;
  logic [MW-1:0]              mag;
  logic [MW-1:0]              mag_sat;
  logic [GW-1:0]              att;

  always_comb begin
    pan_abs = pan_i[amoc_pkg::PAN_W-1] ? amoc_pkg::PAN_W'(-pan_i) : pan_i;
    mag     = MW'(pan_abs);
    mag_sat = (mag > UNITY) ? UNITY : mag;
    att     = GW'(UNITY - mag_sat);
    gain_left_o  = (!pan_i[amoc_pkg::PAN_W-1] && (pan_i != '0)) ? att : GW'(UNITY);
    gain_right_o = pan_i[amoc_pkg::PAN_W-1] ? att : GW'(UNITY);
  end

endmodule

// ===== src/amoc_datapath.sv =====
// Input register, clamp, pan multiply, output formatting and result register.
// Depends on amoc_pkg and amoc_gain.
module amoc_datapath #(
  parameter int GAIN_SHIFT = amoc_pkg::GAIN_SHIFT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_vld_i,
  input  logic signed [amoc_pkg::MIX_W-1:0] left_mix_i,
  input  logic signed [amoc_pkg::MIX_W-1:0] right_mix_i,
  input  amoc_pkg::cfg_t                    cfg_i,
  output logic                              res_vld_o,
  output logic [15:0]                       first_word_o,
  output logic [15:0]                       second_word_o,
  output logic [1:0]                        word_count_o,
  output logic [7:0]                        meter_left_o,
  output logic [7:0]                        meter_right_o
);

  localparam int SW = amoc_pkg::SAMPLE_W;
  localparam int GW = GAIN_SHIFT + 1;
  localparam int PW = SW + GW + 1;

  logic                              vld_q;
  logic signed [amoc_pkg::MIX_W-1:0] left_q, right_q;

  logic                              res_vld_q;
  logic [15:0]                       w0_q, w1_q, w0_d, w1_d;
  logic [1:0]                        cnt_q, cnt_d;
  logic [7:0]                        ml_q, mr_q;

  logic [GW-1:0]                     gain_l, gain_r;
  logic signed [SW-1:0]              clip_l, clip_r, pl, pr;
  logic signed [PW-1:0]              prod_l, prod_r;
  logic signed [SW:0]                sum;

  amoc_gain #(
    .GAIN_SHIFT(GAIN_SHIFT)
  ) u_gain (
    .pan_i       (cfg_i.pan),
    .gain_left_o (gain_l),
    .gain_right_o(gain_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      vld_q     <= in_vld_i;
      res_vld_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i) begin
      left_q  <= left_mix_i;
      right_q <= right_mix_i;
    end
    if (vld_q) begin
      w0_q  <= w0_d;
      w1_q  <= w1_d;
      cnt_q <= cnt_d;
      ml_q  <= {~pl[SW-1], pl[SW-2:SW-8]};
      mr_q  <= {~pr[SW-1], pr[SW-2:SW-8]};
    end
  end

  always_comb begin
    if (left_q[amoc_pkg::MIX_W-1:SW-1] == '0 || left_q[amoc_pkg::MIX_W-1:SW-1] == '1) begin
      clip_l = left_q[SW-1:0];
    end else begin
      clip_l = left_q[amoc_pkg::MIX_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    if (right_q[amoc_pkg::MIX_W-1:SW-1] == '0 || right_q[amoc_pkg::MIX_W-1:SW-1] == '1) begin
      clip_r = right_q[SW-1:0];
    end else begin
      clip_r = right_q[amoc_pkg::MIX_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
    prod_l = clip_l * $signed({1'b0, gain_l});
    prod_r = clip_r * $signed({1'b0, gain_r});
    pl     = prod_l[GAIN_SHIFT +: SW];
    pr     = prod_r[GAIN_SHIFT +: SW];
    sum    = {pl[SW-1], pl} + {pr[SW-1], pr};
  end

  always_comb begin
    unique case (cfg_i.fmt)
      amoc_pkg::FMT_MONO8: begin
        w0_d  = {8'h00, sum[SW:SW-7] ^ amoc_pkg::BYTE_SIGN};
        w1_d  = '0;
        cnt_d = amoc_pkg::WORDS_MONO;
      end
      amoc_pkg::FMT_STEREO8: begin
        w0_d  = {8'h00, pl[SW-1:SW-8] ^ amoc_pkg::BYTE_SIGN};
        w1_d  = {8'h00, pr[SW-1:SW-8] ^ amoc_pkg::BYTE_SIGN};
        cnt_d = amoc_pkg::WORDS_STEREO;
      end
      amoc_pkg::FMT_MONO16: begin
        w0_d  = sum[SW:1];
        w1_d  = '0;
        cnt_d = amoc_pkg::WORDS_MONO;
      end
      amoc_pkg::FMT_STEREO16: begin
        w0_d  = pl;
        w1_d  = pr;
        cnt_d = amoc_pkg::WORDS_STEREO;
      end
    endcase
  end

  assign res_vld_o     = res_vld_q;
  assign first_word_o  = w0_q;
  assign second_word_o = w1_q;
  assign word_count_o  = cnt_q;
  assign meter_left_o  = ml_q;
  assign meter_right_o = mr_q;

  a_res_follows_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_i |=> ##1 res_vld_q)
    else $error("accepted item produced no result");

  a_no_spurious_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(in_vld_i, 2))
    else $error("result without an accepted item");

  a_mono_second_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && cnt_q == amoc_pkg::WORDS_MONO) |-> (w1_q == '0))
    else $error("mono result carries a second word");

  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (cnt_q == amoc_pkg::WORDS_MONO || cnt_q == amoc_pkg::WORDS_STEREO))
    else $error("illegal word count");

endmodule

// ===== src/audio_mix_to_output_converter_unit.sv =====
// Top level of the audio mix to output converter.
// Depends on amoc_pkg, amoc_regs, amoc_datapath.
//
// One stereo frame is taken with start in any cycle; busy stays low, so a frame
// may enter every clock. Each frame gives one result, shown on the result ports
// for exactly one cycle with result_valid_o high; the receiver cannot stall it.
// A frame passes the input register, clamp, pan multiply, format select and
// the result register. Pan and format are to be set over the APB-style port
// only while no frame is in flight; the block itself does not enforce this.
module audio_mix_to_output_converter_unit #(
  parameter int GAIN_SHIFT = amoc_pkg::GAIN_SHIFT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [amoc_pkg::ADDR_W-1:0] paddr,
  input  logic [amoc_pkg::DATA_W-1:0] pwdata,
  output logic [amoc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          left_mix_i,
  input  logic signed [31:0]          right_mix_i,
  output logic                        result_valid_o,
  output logic [15:0]                 first_word_o,
  output logic [15:0]                 second_word_o,
  output logic [1:0]                  word_count_o,
  output logic [7:0]                  meter_left_o,
  output logic [7:0]                  meter_right_o
);

  amoc_pkg::cfg_t cfg;

  assign busy = 1'b0;

  amoc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  amoc_datapath #(
    .GAIN_SHIFT(GAIN_SHIFT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (start && !busy),
    .left_mix_i   (left_mix_i),
    .right_mix_i  (right_mix_i),
    .cfg_i        (cfg),
    .res_vld_o    (result_valid_o),
    .first_word_o (first_word_o),
    .second_word_o(second_word_o),
    .word_count_o (word_count_o),
    .meter_left_o (meter_left_o),
    .meter_right_o(meter_right_o)
  );

endmodule

// ===== dv/audio_mix_to_output_converter_unit_test.sv =====
// Self-checking bench for audio_mix_to_output_converter_unit: stereo frames go in on
// start/busy, pan and format are set over APB, every result is checked field by field.
// Depends on amoc_pkg and the RTL of the converter.
`timescale 1ns / 1ps

module audio_mix_to_output_converter_unit_test;

  localparam int GAIN_SHIFT     = amoc_pkg::GAIN_SHIFT_DEF;
  localparam int ADDR_W         = amoc_pkg::ADDR_W;
  localparam int DATA_W         = amoc_pkg::DATA_W;
  localparam int PAN_W          = amoc_pkg::PAN_W;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_FRAMES  = 78;
  localparam int PHASES         = 13;

  localparam logic [ADDR_W-1:0] PAN_ADDR = {amoc_pkg::REG_PAN, 2'b00};
  localparam logic [ADDR_W-1:0] FMT_ADDR = {amoc_pkg::REG_FMT, 2'b00};

  localparam logic [31:0] EDGE_SAMPLES [10] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF, 32'h0000_8000, 32'hFFFF_8000,
    32'hFFFF_7FFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000
  };

  localparam int PAN_STEPS [PHASES] = '{
    0, 0, -256, 256, -512, 511, -257, 257, -1, 1, 128, 0, 0
  };

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
  } mix_frame_t;

  typedef struct packed {
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [1:0]  word_count;
    logic [7:0]  meter_left;
    logic [7:0]  meter_right;
  } conv_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] left_mix = '0;
  logic signed [31:0] right_mix = '0;
  logic               result_valid;
  logic [15:0]        first_word;
  logic [15:0]        second_word;
  logic [1:0]         word_count;
  logic [7:0]         meter_left;
  logic [7:0]         meter_right;

  mix_frame_t   pending_frames [$];
  conv_result_t expected_outputs [$];
  mix_frame_t   next_frame;

  logic signed [PAN_W-1:0] pan_setting = '0;
  amoc_pkg::fmt_e          fmt_setting = amoc_pkg::FMT_STEREO16;

  bit frame_taken = 1'b0;
  bit progress;
  bit steady = 1'b0;
  int idle_cycles = 0;
  int mismatches = 0;

  audio_mix_to_output_converter_unit #(
    .GAIN_SHIFT(GAIN_SHIFT)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .left_mix_i    (left_mix),
    .right_mix_i   (right_mix),
    .result_valid_o(result_valid),
    .first_word_o  (first_word),
    .second_word_o (second_word),
    .word_count_o  (word_count),
    .meter_left_o  (meter_left),
    .meter_right_o (meter_right)
  );

  always #5 clk = ~clk;

  function automatic conv_result_t convert_frame(logic signed [31:0] left_in,
                                                 logic signed [31:0] right_in,
                                                 logic signed [PAN_W-1:0] pan_in,
                                                 amoc_pkg::fmt_e fmt_in);
    longint unity;
    longint pan;
    longint lgain;
    longint rgain;
    longint l;
    longint r;
    longint mono;
    conv_result_t res;
    unity = longint'(1) <<< GAIN_SHIFT;
    pan = pan_in;
    if (pan < -unity) pan = -unity;
    if (pan > unity) pan = unity;
    if (pan <= 0) begin
      lgain = unity;
      rgain = unity + pan;
    end else begin
      lgain = unity - pan;
      rgain = unity;
    end
    l = left_in;
    r = right_in;
    if (l < -32768) l = -32768;
    if (l > 32767) l = 32767;
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    l = (l * lgain) >>> GAIN_SHIFT;
    r = (r * rgain) >>> GAIN_SHIFT;
    res = '0;
    case (fmt_in)
      amoc_pkg::FMT_MONO8: begin
        mono = (l + r) >>> 9;
        res.first_word = {8'h00, mono[7:0] ^ amoc_pkg::BYTE_SIGN};
        res.word_count = amoc_pkg::WORDS_MONO;
      end
      amoc_pkg::FMT_STEREO8: begin
        res.first_word  = {8'h00, l[15:8] ^ amoc_pkg::BYTE_SIGN};
        res.second_word = {8'h00, r[15:8] ^ amoc_pkg::BYTE_SIGN};
        res.word_count  = amoc_pkg::WORDS_STEREO;
      end
      amoc_pkg::FMT_MONO16: begin
        mono = (l + r) >>> 1;
        res.first_word = mono[15:0];
        res.word_count = amoc_pkg::WORDS_MONO;
      end
      default: begin
        res.first_word  = l[15:0];
        res.second_word = r[15:0];
        res.word_count  = amoc_pkg::WORDS_STEREO;
      end
    endcase
    res.meter_left  = l[15:8] ^ amoc_pkg::BYTE_SIGN;
    res.meter_right = r[15:8] ^ amoc_pkg::BYTE_SIGN;
    return res;
  endfunction

  function automatic logic signed [31:0] random_mix();
    logic [15:0] half;
    int          pick;
    half = $urandom();
    pick = $urandom_range(0, 7);
    case ($urandom_range(0, 5))
      0, 1: random_mix = $urandom();
      2, 3: random_mix = {{16{half[15]}}, half};
      4: random_mix = 32'(pick - 4) + (half[0] ? 32'sd32768 : -32'sd32768);
      default: random_mix = half[0] ? 32'h7FFF_FFFF - pick : 32'h8000_0000 + pick;
    endcase
  endfunction

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", field, want, got);
    end
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && (!start || frame_taken)) begin
      if (pending_frames.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
        next_frame = pending_frames.pop_front();
        left_mix  <= next_frame.left;
        right_mix <= next_frame.right;
        start     <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    frame_taken = 1'b0;
    if (rst_n) begin
      progress = 1'b0;
      if (result_valid) begin
        progress = 1'b1;
        if (expected_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no frame pending: %h", first_word);
        end else begin
          conv_result_t want;
          want = expected_outputs.pop_front();
          check_field("first_word", want.first_word, first_word);
          check_field("second_word", want.second_word, second_word);
          check_field("word_count", 16'(want.word_count), 16'(word_count));
          check_field("meter_left", 16'(want.meter_left), 16'(meter_left));
          check_field("meter_right", 16'(want.meter_right), 16'(meter_right));
        end
      end
      if (start && !busy) begin
        expected_outputs.push_back(convert_frame(left_mix, right_mix, pan_setting, fmt_setting));
        frame_taken = 1'b1;
        progress = 1'b1;
      end
      if (psel && penable && pwrite && pready) progress = 1'b1;
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic signed [PAN_W-1:0] pan_value;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        for (int i = 0; i < 10; i++) begin
          pending_frames.push_back('{EDGE_SAMPLES[i], EDGE_SAMPLES[9 - i]});
          pending_frames.push_back('{EDGE_SAMPLES[i], EDGE_SAMPLES[i]});
        end
      end else begin
        pan_value = (phase >= PHASES - 2) ? PAN_W'($urandom()) : PAN_W'(PAN_STEPS[phase]);
        apb_write(PAN_ADDR, {{(DATA_W - PAN_W){pan_value[PAN_W-1]}}, pan_value});
        apb_write(FMT_ADDR, DATA_W'(phase % 4));
        pan_setting = pan_value;
        fmt_setting = amoc_pkg::fmt_e'(2'(phase % 4));
        steady = (phase == 6);
        for (int i = 0; i < RANDOM_FRAMES; i++) begin
          pending_frames.push_back('{random_mix(), random_mix()});
        end
      end
      while (pending_frames.size() != 0 || start || expected_outputs.size() != 0) begin
        @(negedge clk);
      end
      repeat (4) @(negedge clk);
    end
    if (mismatches == 0 && expected_outputs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/amoc_pkg.sv
src/amoc_regs.sv
src/amoc_gain.sv
src/amoc_datapath.sv
src/audio_mix_to_output_converter_unit.sv
dv/audio_mix_to_output_converter_unit_test.sv
